>>> rtl/core/plst_pkg.sv
// Package for the positional list engine.
// Holds the operation and status codes, field widths and the item and result structs.
// No dependencies.
package plst_pkg;

  localparam int unsigned KindW       = 3;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned PosW        = 8;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned EntryCountW = 5;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 40;

  typedef enum logic [KindW-1:0] {
    KindInsFront = 3'd0,
    KindInsEnd   = 3'd1,
    KindInsPos   = 3'd2,
    KindDelFront = 3'd3,
    KindDelEnd   = 3'd4,
    KindDelPos   = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] removed_value;
    status_e                  status;
    logic [EntryCountW-1:0]   entry_count;
  } result_t;

endpackage

>>> rtl/core/plst_in_stage.sv
// Input register of the positional list engine.
// Captures one beat from the slave side and holds it until the list stage takes it.
// Depends on plst_pkg.
module plst_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  plst_pkg::item_t item_i,
  output logic          item_valid_o,
  output plst_pkg::item_t item_o,
  input  logic          take_i
);
  import plst_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

>>> rtl/core/plst_store.sv
// List storage, operation decode and result register of the positional list engine.
// Applies one insert or delete to the entry array by a parallel shift of the entries.
// Depends on plst_pkg.
module plst_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  plst_pkg::item_t   item_i,
  output logic              take_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output plst_pkg::result_t result_o
);
  import plst_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned WW = ((CW > PosW) ? CW : PosW) + 1;

  logic [ValueW-1:0] entries_q [DEPTH];
  logic [ValueW-1:0] entries_d [DEPTH];
  logic [ValueW-1:0] up_src    [DEPTH];
  logic [ValueW-1:0] dn_src    [DEPTH];
  logic [CW-1:0]     count_q, count_d;
  logic              res_valid_q;
  result_t           result_q, result_d;

  logic [WW-1:0]     pos_w, pos_m1, cnt_w, idx_w;
  logic [IW-1:0]     idx;
  logic              full, empty, do_ins, do_del, adv;
  status_e           status;
  logic [CW+EntryCountW-1:0] cnt_ext;

  assign adv         = item_valid_i && (!res_valid_q || res_ready_i);
  assign take_o      = adv;
  assign res_valid_o = res_valid_q;
  assign result_o    = result_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_src
    if (g == 0) begin : g_first
      assign up_src[g] = item_i.value;
    end else begin : g_rest
      assign up_src[g] = entries_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign dn_src[g] = entries_q[g];
    end else begin : g_inner
      assign dn_src[g] = entries_q[g+1];
    end
  end

  always_comb begin
    pos_w  = WW'(item_i.position);
    pos_m1 = pos_w - WW'(1);
    cnt_w  = WW'(count_q);
    full   = (count_q == CW'(DEPTH));
    empty  = (count_q == '0);
    status = StOk;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx_w  = '0;
    unique case (item_i.kind)
      KindInsFront, KindInsEnd, KindInsPos: begin
        if (full) begin
          status = StFull;
        end else begin
          do_ins = 1'b1;
          if (item_i.kind == KindInsEnd) begin
            idx_w = cnt_w;
          end else if (item_i.kind == KindInsPos && pos_w != '0) begin
            idx_w = (pos_m1 > cnt_w) ? cnt_w : pos_m1;
          end
        end
      end
      KindDelFront, KindDelEnd, KindDelPos: begin
        if (empty) begin
          status = StEmpty;
        end else if (item_i.kind == KindDelEnd) begin
          do_del = 1'b1;
          idx_w  = cnt_w - WW'(1);
        end else if (item_i.kind == KindDelPos) begin
          if (pos_w == '0 || pos_w > cnt_w) begin
            status = StRange;
          end else begin
            do_del = 1'b1;
            idx_w  = pos_m1;
          end
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
      end
    endcase
    idx = idx_w[IW-1:0];

    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_del) begin
      count_d = count_q - CW'(1);
    end

    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins) begin
        if (IW'(i) == idx) begin
          entries_d[i] = item_i.value;
        end else if (IW'(i) > idx) begin
          entries_d[i] = up_src[i];
        end
      end else if (do_del && IW'(i) >= idx) begin
        entries_d[i] = dn_src[i];
      end
    end

    cnt_ext                = {{EntryCountW{1'b0}}, count_d};
    result_d.removed_value = do_del ? entries_q[idx] : '0;
    result_d.status        = status;
    result_d.entry_count   = cnt_ext[EntryCountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result_d;
      if (do_ins || do_del) begin
        entries_q <= entries_d;
      end
    end
  end

endmodule

>>> rtl/core/positional_list_engine_top.sv
// Positional list engine: an accepted beat passes the input register, then the result
// register. Throughput one beat per cycle while the output is ready. The entry registers
// shift in parallel, so each operation sees the list left by the one before it.
// Reset clears the entry count and both handshake registers; the list reads as empty.
// Depends on plst_pkg, plst_in_stage and plst_store.
module positional_list_engine_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value [31:0], position [39:32]
  input  logic [2:0]  s_axis_tuser,  // kind [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // removed_value [31:0], entry_count [36:32], zero fill
  output logic [1:0]  m_axis_tuser   // status [1:0]
);
  import plst_pkg::*;

  item_t   in_item, stage_item;
  result_t result;
  logic    stage_valid, take;

  assign in_item.kind     = kind_e'(s_axis_tuser);
  assign in_item.value    = s_axis_tdata[31:0];
  assign in_item.position = s_axis_tdata[39:32];

  plst_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .item_i       (in_item),
    .item_valid_o (stage_valid),
    .item_o       (stage_item),
    .take_i       (take)
  );

  plst_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .take_o       (take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {3'b000, result.entry_count, result.removed_value};
  assign m_axis_tuser = result.status;

endmodule

>>> rtl/core/plst_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on plst_pkg and positional_list_engine_top.
module plst_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import plst_pkg::*;

  localparam logic [EntryCountW-1:0] FullCount = EntryCountW'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Result beat changed while stalled.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StFull |->
      m_axis_tdata[36:32] == FullCount && m_axis_tdata[31:0] == '0)
    else $error("Full status without a full list.");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StEmpty |->
      m_axis_tdata[36:32] == '0 && m_axis_tdata[31:0] == '0)
    else $error("Empty status with entries held or a value removed.");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("Result beat shown straight after reset.");

endmodule

bind positional_list_engine_top plst_checker #(.DEPTH(DEPTH)) u_plst_checker (.*);
